>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RWR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rwr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RWR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rwr assertion failed");

`endif

>>> hw/rtl/rwr_pkg.sv
package rwr_pkg;

  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned WSIZE_W = 5;
  localparam int unsigned WIN_W   = 6;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [KIND_W-1:0] KIND_END = 2'd1;

  localparam logic [KIND_W-1:0] OUT_ACK     = 2'd0;
  localparam logic [KIND_W-1:0] OUT_DELIVER = 2'd1;
  localparam logic [KIND_W-1:0] OUT_END_ACK = 2'd2;

  localparam logic [ADDR_W-3:0]  REG_WINDOW_SIZE   = 1'b0;
  localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RESET = 5'd16;

  typedef struct packed {
    logic             is_end;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  num;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
    logic              last;
  } res_t;

endpackage

>>> hw/rtl/reorder_window_receiver_top.sv
// An accepted item is registered in the front, queued in the command queue and then
// evaluated by the back, whose results enter the result queue; an end item or a new
// out-of-order data item yields one acknowledgement. In-order release marks the slot,
// then delivers each filled slot in order and ends with the cumulative acknowledgement.
// Input and result queues let the front accept items while results wait to be popped.
// Reset is asynchronous and active low; it empties both queues, clears all slot flags,
// sets the next expected number to zero and the window size register to 16.
module reorder_window_receiver_top
  import rwr_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              push,
  output logic              full,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [SEQ_W-1:0]  seq_number_i,
  input  logic [LEN_W-1:0]  payload_length_i,
  input  logic              checksum_ok_i,
  output logic              empty,
  input  logic              pop,
  output logic [KIND_W-1:0] out_kind_o,
  output logic [SEQ_W-1:0]  seq_or_ack_o,
  output logic [SLOT_W-1:0] deliver_slot_o,
  output logic [LEN_W-1:0]  deliver_length_o,
  output logic              last_o
);

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 4;

  logic [WSIZE_W-1:0] window_size_q;
  logic               cfg_we;
  logic               cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t               cmd_in, cmd_head;
  logic               res_push, res_full;
  res_t               res_in, res_head;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[ADDR_W-1:2] == REG_WINDOW_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WINDOW_SIZE_RESET;
    end else if (cfg_we) begin
      window_size_q <= pwdata[WSIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1:2] == REG_WINDOW_SIZE) begin
      prdata = DATA_W'(window_size_q);
    end
  end

  rwr_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .kind_i           (kind_i),
    .seq_number_i     (seq_number_i),
    .payload_length_i (payload_length_i),
    .checksum_ok_i    (checksum_ok_i),
    .cmd_push_o       (cmd_push),
    .cmd_o            (cmd_in),
    .cmd_full_i       (cmd_full)
  );

  rwr_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_head),
    .empty_o (cmd_empty)
  );

  rwr_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .window_size_i (window_size_q),
    .cmd_valid_i   (!cmd_empty),
    .cmd_i         (cmd_head),
    .cmd_pop_o     (cmd_pop),
    .res_push_o    (res_push),
    .res_o         (res_in),
    .res_full_i    (res_full)
  );

  rwr_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_head),
    .empty_o (empty)
  );

  assign out_kind_o       = res_head.kind;
  assign seq_or_ack_o     = res_head.num;
  assign deliver_slot_o   = res_head.slot;
  assign deliver_length_o = res_head.len;
  assign last_o           = res_head.last;

endmodule

>>> hw/rtl/rwr_fifo.sv
module rwr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> hw/rtl/rwr_front.sv
module rwr_front
  import rwr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [SEQ_W-1:0]  seq_number_i,
  input  logic [LEN_W-1:0]  payload_length_i,
  input  logic              checksum_ok_i,
  output logic              cmd_push_o,
  output cmd_t              cmd_o,
  input  logic              cmd_full_i
);

  logic valid_q, valid_d;
  cmd_t cmd_q;
  logic take;

  assign full       = valid_q && cmd_full_i;
  assign take       = push && !full;
  assign cmd_push_o = valid_q;
  assign cmd_o      = cmd_q;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && !cmd_full_i) begin
      valid_d = 1'b0;
    end
    if (take && checksum_ok_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && checksum_ok_i) begin
      cmd_q.is_end <= (kind_i == KIND_END);
      cmd_q.seq    <= seq_number_i;
      cmd_q.len    <= payload_length_i;
    end
  end

endmodule

>>> hw/rtl/rwr_back.sv
module rwr_back
  import rwr_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [WSIZE_W-1:0] window_size_i,
  input  logic               cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               cmd_pop_o,
  output logic               res_push_o,
  output res_t               res_o,
  input  logic               res_full_i
);

  localparam int unsigned SW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_EVAL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  state_e                  state_q, state_d;
  logic [SEQ_W-1:0]        next_exp_q, next_exp_d;
  logic [SW-1:0]           next_slot_q, next_slot_d;
  logic [WINDOW_DEPTH-1:0] slot_full_q, slot_full_d;
  logic [LEN_W-1:0]        slot_len_q [WINDOW_DEPTH];

  logic [WIN_W-1:0] win;
  logic [SEQ_W-1:0] seq_off;
  logic             in_win;
  logic [SW:0]      slot_sum;
  logic [SW-1:0]    slot;
  logic [SW-1:0]    next_slot_inc;
  logic             len_we;

  always_comb begin
    if (window_size_i == '0) begin
      win = WIN_W'(1);
    end else if (WIN_W'(window_size_i) > WIN_W'(WINDOW_DEPTH)) begin
      win = WIN_W'(WINDOW_DEPTH);
    end else begin
      win = WIN_W'(window_size_i);
    end
  end

  assign seq_off  = cmd_i.seq - next_exp_q;
  assign in_win   = (seq_off < SEQ_W'(win));
  assign slot_sum = {1'b0, next_slot_q} + {1'b0, seq_off[SW-1:0]};
  assign slot     = (slot_sum >= (SW + 1)'(WINDOW_DEPTH))
                    ? SW'(slot_sum - (SW + 1)'(WINDOW_DEPTH)) : slot_sum[SW-1:0];
  assign next_slot_inc = (next_slot_q == SW'(WINDOW_DEPTH - 1))
                         ? '0 : next_slot_q + SW'(1);

  always_comb begin
    state_d     = state_q;
    next_exp_d  = next_exp_q;
    next_slot_d = next_slot_q;
    slot_full_d = slot_full_q;
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    res_o       = '0;
    len_we      = 1'b0;
    unique case (state_q)
      ST_EVAL: begin
        if (cmd_valid_i) begin
          if (cmd_i.is_end) begin
            if (!res_full_i) begin
              res_push_o  = 1'b1;
              res_o.kind  = OUT_END_ACK;
              res_o.num   = cmd_i.seq;
              res_o.last  = 1'b1;
              cmd_pop_o   = 1'b1;
              next_exp_d  = '0;
              next_slot_d = '0;
              slot_full_d = '0;
            end
          end else if (!in_win || slot_full_q[slot]) begin
            cmd_pop_o = 1'b1;
          end else if (seq_off != '0) begin
            if (!res_full_i) begin
              res_push_o        = 1'b1;
              res_o.kind        = OUT_ACK;
              res_o.num         = next_exp_q;
              res_o.last        = 1'b1;
              cmd_pop_o         = 1'b1;
              slot_full_d[slot] = 1'b1;
              len_we            = 1'b1;
            end
          end else begin
            cmd_pop_o         = 1'b1;
            slot_full_d[slot] = 1'b1;
            len_we            = 1'b1;
            state_d           = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (slot_full_q[next_slot_q]) begin
            res_o.kind               = OUT_DELIVER;
            res_o.num                = next_exp_q;
            res_o.slot               = SLOT_W'(next_slot_q);
            res_o.len                = slot_len_q[next_slot_q];
            slot_full_d[next_slot_q] = 1'b0;
            next_exp_d               = next_exp_q + SEQ_W'(1);
            next_slot_d              = next_slot_inc;
          end else begin
            res_o.kind = OUT_ACK;
            res_o.num  = next_exp_q;
            res_o.last = 1'b1;
            state_d    = ST_EVAL;
          end
        end
      end
      default: begin
        state_d = ST_EVAL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_EVAL;
      next_exp_q  <= '0;
      next_slot_q <= '0;
      slot_full_q <= '0;
    end else begin
      state_q     <= state_d;
      next_exp_q  <= next_exp_d;
      next_slot_q <= next_slot_d;
      slot_full_q <= slot_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      slot_len_q[slot] <= cmd_i.len;
    end
  end

endmodule

>>> hw/rtl/rwr_checker.sv
`include "assert_macros.svh"

module rwr_checker
  import rwr_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input logic [KIND_W-1:0] out_kind_o,
  input logic [SLOT_W-1:0] deliver_slot_o,
  input logic [LEN_W-1:0]  deliver_length_o,
  input logic              last_o
);

  logic kind_ok;
  logic is_deliver;
  logic no_slot;

  assign kind_ok    = (out_kind_o == OUT_ACK) || (out_kind_o == OUT_DELIVER) ||
                      (out_kind_o == OUT_END_ACK);
  assign is_deliver = (out_kind_o == OUT_DELIVER);
  assign no_slot    = (deliver_slot_o == '0) && (deliver_length_o == '0);

  `RWR_ASSERT_IMP(a_kind_known, clk_i, rst_ni, !empty, kind_ok)
  `RWR_ASSERT_IMP(a_ack_is_last, clk_i, rst_ni, !empty && !is_deliver, last_o)
  `RWR_ASSERT_IMP(a_deliver_not_last, clk_i, rst_ni, !empty && is_deliver, !last_o)
  `RWR_ASSERT_IMP(a_ack_no_slot, clk_i, rst_ni, !empty && !is_deliver, no_slot)
  `RWR_ASSERT_NXT(a_result_held, clk_i, rst_ni, !empty && !pop, !empty)

endmodule

bind reorder_window_receiver_top rwr_checker u_rwr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .empty            (empty),
  .pop              (pop),
  .out_kind_o       (out_kind_o),
  .deliver_slot_o   (deliver_slot_o),
  .deliver_length_o (deliver_length_o),
  .last_o           (last_o)
);
